FILE: design/scpa_pkg.sv
package scpa_pkg;

	// Fixed field widths
	localparam int ADDR_W  = 15;
	localparam int SIZE_W  = 16;
	localparam int CLASS_W = 5;

	// Parameter defaults
	localparam int POOL_BYTES_DEF = 4096;
	localparam int MAX_POOLS_DEF  = 8;
	localparam int FREE_DEPTH_DEF = 16;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_OVERSIZE  = 3'd2,
		ST_NOMEM     = 3'd3,
		ST_STACKFULL = 3'd4
	} status_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [SIZE_W-1:0]   req_size;
		logic [ADDR_W-1:0]   block_addr;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   granted_addr;
		logic                from_free_list;
	} rsp_t;

	// Free stack command and status
	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_stat_t;

	// Smallest k with 2^k >= size, for size 1..65535
	function automatic logic [CLASS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0]  m;
		logic [CLASS_W-1:0] k;
		m = size - 1'b1;
		k = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (m[i]) k = CLASS_W'(i + 1);
		end
		return k;
	endfunction

	// Number of classes k with 2^k <= pool_bytes
	function automatic int num_classes(input int pool_bytes);
		int n;
		n = 0;
		for (int i = 0; i <= SIZE_W; i++) begin
			if ((longint'(1) << i) <= longint'(pool_bytes)) n = i + 1;
		end
		return n;
	endfunction

endpackage

FILE: design/scpa_alu.sv
// Shared adder with pool-limit compare
module scpa_alu #(
	parameter int           W     = 18,
	parameter logic [W-1:0] LIMIT = '0
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] sum,
	output logic         fits
);

	// add, then check against the pool size
	assign sum  = a + b;
	assign fits = (sum <= LIMIT);

endmodule

FILE: design/scpa_pool_heads.sv
// Bytes used per pool, one write and one registered read per cycle
module scpa_pool_heads #(
	parameter int MAX_POOLS = 8,
	parameter int HEAD_W    = 13,
	parameter int IDX_W     = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [HEAD_W-1:0] rd_head,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [HEAD_W-1:0] wr_head
);

	logic [HEAD_W-1:0]    mem [MAX_POOLS];
	logic [MAX_POOLS-1:0] valid_q;
	logic [HEAD_W-1:0]    rd_data_q;
	logic                 rd_valid_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_head;
		rd_data_q <= mem[rd_idx];
	end

	// mark written entries; unwritten pools read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_idx] <= 1'b1;
			rd_valid_q <= valid_q[rd_idx];
		end
	end

	assign rd_head = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: design/scpa_free_stack.sv
// Per-class LIFO stacks of freed addresses
module scpa_free_stack #(
	parameter int NUM_CLASSES = 13,
	parameter int CLS_W       = 4,
	parameter int FREE_DEPTH  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [CLS_W-1:0]            cls,
	input  scpa_pkg::stk_cmd_t          cmd,
	input  logic [scpa_pkg::ADDR_W-1:0] push_data,
	output scpa_pkg::stk_stat_t         stat,
	output logic [scpa_pkg::ADDR_W-1:0] rd_data
);

	localparam int SIDX_W    = $clog2(FREE_DEPTH);
	localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_CLASSES << SIDX_W;

	logic [scpa_pkg::ADDR_W-1:0] mem [MEM_DEPTH];
	logic [CNT_W-1:0]            counts_q [NUM_CLASSES];
	logic [CNT_W-1:0]            cnt_cur;
	logic [CNT_W-1:0]            cnt_m1;
	logic [CLS_W+SIDX_W-1:0]     push_addr;
	logic [CLS_W+SIDX_W-1:0]     pop_addr;

	assign cnt_cur    = counts_q[cls];
	assign cnt_m1     = cnt_cur - 1'b1;
	assign push_addr  = {cls, cnt_cur[SIDX_W-1:0]};
	assign pop_addr   = {cls, cnt_m1[SIDX_W-1:0]};
	assign stat.empty = (cnt_cur == '0);
	assign stat.full  = (cnt_cur == CNT_W'(FREE_DEPTH));

	// push writes the top slot, pop reads the one below
	always_ff @(posedge clk) begin
		if (cmd.push) mem[push_addr] <= push_data;
		if (cmd.pop) rd_data <= mem[pop_addr];
	end

	// advance the fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) counts_q[i] <= '0;
		end else if (cmd.push) begin
			counts_q[cls] <= cnt_cur + 1'b1;
		end else if (cmd.pop) begin
			counts_q[cls] <= cnt_m1;
		end
	end

endmodule

FILE: design/size_class_pool_allocator.sv
// Power-of-two size-class pool allocator. A request is taken when start is high and busy
// is low; exactly one response follows, shown on rsp for the single cycle that done is high,
// and it cannot be held off. Sizes round up to a power of two; an alloc reuses the newest
// freed block of its class, else takes room from the first open pool that fits, else opens
// the next pool while fewer than MAX_POOLS are open. Zero-size, oversize and free requests
// are answered from the decode state, reuses from the pop state after the free stack is read.
// An alloc that searches the pools visits at most MAX_POOLS of them in turn: one shared
// adder checks and advances one pool at a time, and each pool entry is read from a memory
// with a registered port. The next request may start while the previous response is shown.
module size_class_pool_allocator #(
	parameter int POOL_BYTES = scpa_pkg::POOL_BYTES_DEF,
	parameter int MAX_POOLS  = scpa_pkg::MAX_POOLS_DEF,
	parameter int FREE_DEPTH = scpa_pkg::FREE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  scpa_pkg::req_t  req,
	output logic            done,
	output scpa_pkg::rsp_t  rsp
);

	localparam int NUM_CLASSES = scpa_pkg::num_classes(POOL_BYTES);
	localparam int CLS_W       = $clog2(NUM_CLASSES);
	localparam int HEAD_W      = $clog2(POOL_BYTES + 1);
	localparam int W           = (HEAD_W + 1 > scpa_pkg::ADDR_W) ? HEAD_W + 1 : scpa_pkg::ADDR_W;
	localparam int IDX_W       = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
	localparam int OPEN_W      = $clog2(MAX_POOLS + 1);
	localparam logic [W-1:0] POOL_W = W'(POOL_BYTES);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DECODE   = 8'b0000_0010,
		S_POP      = 8'b0000_0100,
		S_SCAN_RD  = 8'b0000_1000,
		S_SCAN_FIT = 8'b0001_0000,
		S_GRANT    = 8'b0010_0000,
		S_NEXT     = 8'b0100_0000,
		S_OPEN     = 8'b1000_0000
	} state_t;

	state_t                          state_q, state_d;
	scpa_pkg::req_t                  req_q;
	logic [scpa_pkg::CLASS_W-1:0]    cls_in;
	logic [scpa_pkg::CLASS_W-1:0]    cls_q;
	logic                            zero_q;
	logic                            over_q;
	logic [OPEN_W-1:0]               pools_open_q;
	logic [IDX_W-1:0]                idx_q;
	logic [W-1:0]                    base_q;
	logic [HEAD_W-1:0]               head_q;
	logic [HEAD_W-1:0]               newhead_q;
	logic [W-1:0]                    blk;
	logic                            accept;
	logic                            last_pool;

	// shared unit
	logic [W-1:0]                    alu_a, alu_b, alu_sum;
	logic                            alu_fits;

	// stack and heads
	scpa_pkg::stk_cmd_t              stk_cmd;
	scpa_pkg::stk_stat_t             stk_stat;
	logic [scpa_pkg::ADDR_W-1:0]     stk_rd_data;
	logic [HEAD_W-1:0]               hd_rd_head;
	logic                            hd_wr_en;
	logic [IDX_W-1:0]                hd_wr_idx;
	logic [HEAD_W-1:0]               hd_wr_head;

	// response
	logic                            fin;
	scpa_pkg::rsp_t                  fin_rsp;
	logic                            done_q;
	scpa_pkg::rsp_t                  rsp_q;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cls_in    = scpa_pkg::size_class(req.req_size);
	assign blk       = W'(1) << cls_q;
	assign last_pool = ((OPEN_W'(idx_q) + 1'b1) == pools_open_q);
	assign done      = done_q;
	assign rsp       = rsp_q;

	scpa_alu #(
		.W     (W),
		.LIMIT (POOL_W)
	) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.sum  (alu_sum),
		.fits (alu_fits)
	);

	scpa_free_stack #(
		.NUM_CLASSES (NUM_CLASSES),
		.CLS_W       (CLS_W),
		.FREE_DEPTH  (FREE_DEPTH)
	) u_free_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_q[CLS_W-1:0]),
		.cmd       (stk_cmd),
		.push_data (req_q.block_addr),
		.stat      (stk_stat),
		.rd_data   (stk_rd_data)
	);

	scpa_pool_heads #(
		.MAX_POOLS (MAX_POOLS),
		.HEAD_W    (HEAD_W),
		.IDX_W     (IDX_W)
	) u_pool_heads (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (idx_q),
		.rd_head (hd_rd_head),
		.wr_en   (hd_wr_en),
		.wr_idx  (hd_wr_idx),
		.wr_head (hd_wr_head)
	);

	// sequencer: next state, unit operands, store writes and response
	always_comb begin
		state_d    = state_q;
		alu_a      = '0;
		alu_b      = '0;
		stk_cmd    = '0;
		hd_wr_en   = 1'b0;
		hd_wr_idx  = idx_q;
		hd_wr_head = newhead_q;
		fin        = 1'b0;
		fin_rsp    = '{status: scpa_pkg::ST_OK, granted_addr: '0, from_free_list: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (zero_q) begin
					fin            = 1'b1;
					fin_rsp.status = scpa_pkg::ST_ZERO;
					state_d        = S_IDLE;
				end else if (over_q) begin
					fin            = 1'b1;
					fin_rsp.status = scpa_pkg::ST_OVERSIZE;
					state_d        = S_IDLE;
				end else if (req_q.opcode == scpa_pkg::OP_FREE) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (stk_stat.full) fin_rsp.status = scpa_pkg::ST_STACKFULL;
					else stk_cmd.push = 1'b1;
				end else if (!stk_stat.empty) begin
					stk_cmd.pop = 1'b1;
					state_d     = S_POP;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_POP: begin
				fin                    = 1'b1;
				fin_rsp.granted_addr   = stk_rd_data;
				fin_rsp.from_free_list = 1'b1;
				state_d                = S_IDLE;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_FIT;
			end
			S_SCAN_FIT: begin
				alu_a = W'(hd_rd_head);
				alu_b = blk;
				if (alu_fits) state_d = S_GRANT;
				else if (last_pool) state_d = S_OPEN;
				else state_d = S_NEXT;
			end
			S_GRANT: begin
				alu_a                = base_q;
				alu_b                = W'(head_q);
				hd_wr_en             = 1'b1;
				fin                  = 1'b1;
				fin_rsp.granted_addr = alu_sum[scpa_pkg::ADDR_W-1:0];
				state_d              = S_IDLE;
			end
			S_NEXT: begin
				alu_a   = base_q;
				alu_b   = POOL_W;
				state_d = S_SCAN_RD;
			end
			S_OPEN: begin
				alu_a   = base_q;
				alu_b   = POOL_W;
				fin     = 1'b1;
				state_d = S_IDLE;
				if (pools_open_q < OPEN_W'(MAX_POOLS)) begin
					hd_wr_en             = 1'b1;
					hd_wr_idx            = pools_open_q[IDX_W-1:0];
					hd_wr_head           = blk[HEAD_W-1:0];
					fin_rsp.granted_addr = alu_sum[scpa_pkg::ADDR_W-1:0];
				end else begin
					fin_rsp.status = scpa_pkg::ST_NOMEM;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold the request and its class, the scanned head and the response
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			cls_q  <= cls_in;
			zero_q <= (req.req_size == '0);
			over_q <= (cls_in > scpa_pkg::CLASS_W'(NUM_CLASSES - 1));
		end
		if (state_q == S_SCAN_FIT) begin
			head_q    <= hd_rd_head;
			newhead_q <= alu_sum[HEAD_W-1:0];
		end
		if (fin) rsp_q <= fin_rsp;
	end

	// advance state, scan position and pool count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pools_open_q <= OPEN_W'(1);
			idx_q        <= '0;
			base_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_DECODE) begin
				idx_q  <= '0;
				base_q <= '0;
			end
			if (state_q == S_NEXT) begin
				idx_q  <= idx_q + 1'b1;
				base_q <= alu_sum;
			end
			if (state_q == S_OPEN && pools_open_q < OPEN_W'(MAX_POOLS))
				pools_open_q <= pools_open_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_pools_open_range: assert property (@(posedge clk) disable iff (!arst_n)
		pools_open_q != '0 && pools_open_q <= OPEN_W'(MAX_POOLS))
		else $error("open pool count out of range");

	a_reuse_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.from_free_list && rsp.status != scpa_pkg::ST_OK))
		else $error("reuse flagged on a failed request");

	a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != scpa_pkg::ST_OK |-> rsp.granted_addr == '0)
		else $error("address given on a failed request");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("request taken without going busy");

	a_scan_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_RD |-> OPEN_W'(idx_q) < pools_open_q)
		else $error("scan beyond open pools");
`endif

endmodule
